>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro checks a property on the rising clock edge, outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every edge outside reset.
`define QW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define QW_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define QW_ASSERT(lbl, clk, rst_n, prop, msg)
`define QW_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> rtl/qwsce_pkg.sv
package qwsce_pkg;

    // Field widths fixed by the block's channels.
    localparam int WORD_W     = 64;
    localparam int LEN_W      = 64;
    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 2;

    // Default for the longest supported word, in digits.
    localparam int MAX_LENGTH_DEF = 32;

    // Digits summed per cycle and compare-subtract steps per cycle.
    localparam int LANES     = 8;
    localparam int MOD_LANES = 4;

    // Register reset values.
    localparam logic [CFG_W-1:0] WORD_LENGTH_RST    = 6'd8;
    localparam logic [CFG_W-1:0] TARGET_RESIDUE_RST = 6'd0;

    // Item kinds on the input channel.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_EXAM  = 1'b1;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORD_LENGTH    = 2'd0,
        REG_TARGET_RESIDUE = 2'd1
    } t_reg_idx;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_MOD,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_run;
        logic start_exam;
        logic sum_step;
        logic mod_step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_empty;
        logic sum_last;
        logic mod_last;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/qwsce_ifs.sv
// Input item channel: start or examine requests.
interface qwsce_in_if
    import qwsce_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [WORD_W-1:0] first_word;
    logic [LEN_W-1:0]  run_length;

    modport source (output valid, output kind, output first_word, output run_length,
                    input ready);
    modport sink   (input valid, input kind, input first_word, input run_length,
                    output ready);
endinterface

// Result item channel.
interface qwsce_out_if
    import qwsce_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_digits;
    logic              is_codeword;
    logic              last_of_run;

    modport source (output valid, output word_digits, output is_codeword,
                    output last_of_run, input ready);
    modport sink   (input valid, input word_digits, input is_codeword,
                    input last_of_run, output ready);
endinterface

// Configuration write channel.
interface qwsce_cfg_if
    import qwsce_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/qwsce_ctrl.sv
`include "assert_macros.svh"

module qwsce_ctrl
    import qwsce_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_kind,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    logic in_take;

    assign in_take = (r_state == S_IDLE) && i_in_valid;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: weighted sum, then residue, then hand over the result.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take && (i_in_kind == KIND_EXAM) && !i_stat.run_empty) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (i_stat.sum_last) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_stat.mod_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs: an item is taken only while idle.
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.load_run   = in_take && (i_in_kind == KIND_START);
                o_cmd.start_exam = in_take && (i_in_kind == KIND_EXAM) && !i_stat.run_empty;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            S_OUT: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    `QW_ASSERT(a_cmd_onehot, i_clk, i_rst_n, ($onehot0(o_cmd)), "more than one command at once")
    `QW_ASSERT(a_exam_to_sum, i_clk, i_rst_n, (o_cmd.start_exam |=> r_state == S_SUM), "examine did not enter the sum phase")
    `QW_ASSERT(a_finish_idle, i_clk, i_rst_n, (o_cmd.finish |=> (r_state == S_IDLE) && o_in_ready), "controller did not return to idle after a result")

endmodule

>>> rtl/qwsce_dp.sv
`include "assert_macros.svh"

module qwsce_dp
    import qwsce_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [WORD_W-1:0]    i_first_word,
    input  logic [LEN_W-1:0]     i_run_length,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [WORD_W-1:0]    o_word_digits,
    output logic                 o_is_codeword,
    output logic                 o_last_of_run
);

    // Sizes of the sum, the residue unit and its step counter.
    localparam int SUM_MAX   = 3 * MAX_LENGTH * (MAX_LENGTH + 1) / 2;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam int REM_W     = (SUM_W > CFG_W) ? SUM_W : CFG_W;
    localparam int MOD_CYC   = (REM_W + MOD_LANES - 1) / MOD_LANES;
    localparam int STEP_W    = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;
    localparam int TOP_SHIFT = MOD_LANES * MOD_CYC - 1;
    localparam int DIV_W     = CFG_W + MOD_LANES * MOD_CYC;
    localparam int DIGITS    = WORD_W / 2;

    logic [CFG_W-1:0]  r_word_length;
    logic [CFG_W-1:0]  r_target;
    logic [WORD_W-1:0] r_idx;
    logic [LEN_W-1:0]  r_rem;

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_shift;
    logic [CFG_W-1:0]  r_wt;
    logic [CFG_W-1:0]  r_mod;
    logic [REM_W-1:0]  r_acc;
    logic [REM_W-1:0]  r_tgt;
    logic [DIV_W-1:0]  r_msh;
    logic [STEP_W-1:0] r_step;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_match;
    logic              r_out_last;

    logic [CFG_W-1:0]  eff_len;
    logic [WORD_W-1:0] word_mask;
    logic [REM_W-1:0]  chunk_sum;
    logic [REM_W-1:0]  n_acc_sum;
    logic [DIV_W-1:0]  v_a;
    logic [DIV_W-1:0]  v_t;
    logic [DIV_W-1:0]  v_d;
    logic [REM_W-1:0]  n_acc_mod;
    logic [REM_W-1:0]  n_tgt_mod;
    logic              match;
    logic              last;
    logic              out_free;

    // Word length clamped to the supported range.
    always_comb begin
        if (r_word_length == '0) begin
            eff_len = CFG_W'(1);
        end else if (r_word_length > CFG_W'(MAX_LENGTH)) begin
            eff_len = CFG_W'(MAX_LENGTH);
        end else begin
            eff_len = r_word_length;
        end
    end

    // Only the low digits of the index belong to the word.
    always_comb begin
        for (int p = 0; p < DIGITS; p++) begin
            word_mask[2*p +: 2] = (CFG_W'(p) < eff_len) ? 2'b11 : 2'b00;
        end
    end

    // One chunk of digits, least significant first; weight falls by one per digit.
    always_comb begin
        chunk_sum = '0;
        for (int j = 0; j < LANES; j++) begin
            chunk_sum = chunk_sum
                + REM_W'(r_wt - CFG_W'(j)) * REM_W'(r_shift[2*j +: 2]);
        end
        n_acc_sum = r_acc + chunk_sum;
    end

    // Restoring reduction of sum and target by the modulus, a few bits per cycle.
    always_comb begin
        v_a = DIV_W'(r_acc);
        v_t = DIV_W'(r_tgt);
        v_d = '0;
        for (int j = 0; j < MOD_LANES; j++) begin
            v_d = r_msh >> j;
            if (v_a >= v_d) begin
                v_a = v_a - v_d;
            end
            if (v_t >= v_d) begin
                v_t = v_t - v_d;
            end
        end
        n_acc_mod = REM_W'(v_a);
        n_tgt_mod = REM_W'(v_t);
    end

    assign match    = (r_acc == r_tgt);
    assign last     = (r_rem == LEN_W'(1));
    assign out_free = !r_out_valid || i_out_ready;

    // Status for the controller.
    always_comb begin
        o_stat.run_empty = (r_rem == '0);
        o_stat.sum_last  = (r_wt <= CFG_W'(LANES));
        o_stat.mod_last  = (r_step == STEP_W'(MOD_CYC - 1));
        o_stat.out_free  = out_free;
    end

    // Configuration registers and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_length <= WORD_LENGTH_RST;
            r_target      <= TARGET_RESIDUE_RST;
            r_idx         <= '0;
            r_rem         <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_WORD_LENGTH: begin
                        r_word_length <= i_cfg_data;
                    end
                    REG_TARGET_RESIDUE: begin
                        r_target <= i_cfg_data;
                    end
                    default: begin
                        r_target <= r_target;
                    end
                endcase
            end
            if (i_cmd.load_run) begin
                r_idx <= i_first_word;
                r_rem <= i_run_length;
            end else if (i_cmd.finish) begin
                r_idx <= r_idx + WORD_W'(1);
                r_rem <= r_rem - LEN_W'(1);
            end
        end
    end

    // Working registers of one examined word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.start_exam) begin
            r_step <= '0;
        end else if (i_cmd.mod_step) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_exam) begin
            r_word  <= r_idx & word_mask;
            r_shift <= r_idx & word_mask;
            r_wt    <= eff_len;
            r_mod   <= eff_len + CFG_W'(1);
            r_acc   <= '0;
            r_tgt   <= REM_W'(r_target);
            r_msh   <= (DIV_W'(eff_len) + DIV_W'(1)) << TOP_SHIFT;
        end else if (i_cmd.sum_step) begin
            r_acc   <= n_acc_sum;
            r_shift <= r_shift >> (2 * LANES);
            r_wt    <= r_wt - CFG_W'(LANES);
        end else if (i_cmd.mod_step) begin
            r_acc <= n_acc_mod;
            r_tgt <= n_tgt_mod;
            r_msh <= r_msh >> MOD_LANES;
        end
    end

    // Output register: a result item waits here until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish && (match || last)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && (match || last)) begin
            r_out_word  <= r_word;
            r_out_match <= match;
            r_out_last  <= last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_word_digits = r_out_word;
    assign o_is_codeword = r_out_match;
    assign o_last_of_run = r_out_last;

    `QW_ASSERT(a_sum_reduced, i_clk, i_rst_n, (i_cmd.finish |-> r_acc < REM_W'(r_mod)), "sum")
    `QW_ASSERT(a_tgt_reduced, i_clk, i_rst_n, (i_cmd.finish |-> r_tgt < REM_W'(r_mod)), "target")
    `QW_ASSERT(a_run_alive, i_clk, i_rst_n, (i_cmd.finish |-> r_rem != '0), "no run in progress")

endmodule

>>> rtl/quaternary_weighted_sum_code_enumerator.sv
// Quaternary weighted-sum code enumerator.
// Input channel i_in: kind 0 starts a run at first_word with run_length words
// and gives no result; kind 1 examines the current word of the run.
// Output channel o_out: a result item carries the examined word, whether its
// weighted digit sum matches the target residue, and whether it closed the run.
// A result is given only for a matching word or the last word of a run.
// Configuration channel i_cfg: index 0 word_length, index 1 target_residue;
// always ready, to be written while the block is idle.
// Sequence: a start item is taken while idle. An examine item loads its
// word while idle, then passes eight digits per cycle through the
// weighted-sum adder, then goes through the shared residue unit with four
// compare-subtract steps per cycle, then reaches its result cycle.
// One item is in work at a time; i_in.ready is high only while idle.
// Reset (synchronous, active low) clears the run, the output register and
// restores word_length 8, target_residue 0.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and computed, then waits in its result cycle, whether it
// gives a result or not, until the output register is free.
module quaternary_weighted_sum_code_enumerator
    import qwsce_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qwsce_in_if.sink   i_in,
    qwsce_out_if.source o_out,
    qwsce_cfg_if.sink  i_cfg
);

    t_cmd  cmd;
    t_stat stat;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Controller sequencing one item at a time.
    qwsce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath with run state, sum, residue unit and output register.
    qwsce_dp #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_first_word  (i_in.first_word),
        .i_run_length  (i_in.run_length),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_word_digits (o_out.word_digits),
        .o_is_codeword (o_out.is_codeword),
        .o_last_of_run (o_out.last_of_run)
    );

endmodule
